FILE: hdl/max_priority_queue_core_assert.svh
// Assertion macros for the sorted priority queue core and its port checker.
// No dependencies; included by the checker module.
`ifndef MAX_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Concurrent assertion on an explicit clock and reset.
`define MPQ_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MPQ_ASSERT(lbl, prop, msg) `MPQ_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

FILE: hdl/mpq_pkg.sv
// Shared types and codes for the sorted priority queue core.
// No dependencies; imported by the cell, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

   localparam int DefaultDepth = 16;
   localparam int ValueWidth   = 32;
   localparam int PrioWidth    = 16;

   localparam logic [1:0] ActEnqueue = 2'd0;
   localparam logic [1:0] ActDequeue = 2'd1;
   localparam logic [1:0] ActPeek    = 2'd2;

   localparam logic [1:0] StatusOk        = 2'd0;
   localparam logic [1:0] StatusUnderflow = 2'd1;
   localparam logic [1:0] StatusOverflow  = 2'd2;

   typedef struct packed {
      logic signed [PrioWidth-1:0]  prio;
      logic signed [ValueWidth-1:0] value;
   } entry_type;

   typedef struct packed {
      logic enq;
      logic deq;
   } ctl_type;

endpackage

`default_nettype wire

FILE: hdl/mpq_cell.sv
// One slot of the sorted cell row: holds an entry and moves it one place per transfer.
// Depends on mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpq_cell
   import mpq_pkg::*;
(
   input  wire logic      clock,
   input  wire ctl_type   ctl,
   input  wire logic      occupied,
   input  wire entry_type new_entry,
   input  wire entry_type prev_entry,
   input  wire logic      prev_keep,
   input  wire entry_type next_entry,
   output entry_type      entry,
   output logic           keep
);

   entry_type entry_ff;
   entry_type entry_in;

   assign keep  = occupied && (entry_ff.prio >= new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.enq) begin
         if (!keep) begin
            entry_in = prev_keep ? new_entry : prev_entry;
         end
      end else if (ctl.deq) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: hdl/max_priority_queue_core.sv
// Sorted max-priority queue: control, count and result register over a row of cells.
// Depends on mpq_pkg and mpq_cell.
//
//   channel | direction | tdata (low bit up)                    | tuser
//   req     | in        | item_value, item_priority             | action
//   rsp     | out       | head_value, entry_count, is_empty, pad | status
//
// For every item, all cells compare and move on the same clock edge.
// Reset clears the count and the result valid flag; slot contents and result fields need no clearing.
// req_tready is high while the result register is empty or being taken.
// Results stay in the result register until transferred.
`timescale 1ns / 1ps
`default_nettype none

module max_priority_queue_core
   import mpq_pkg::*;
#(
   parameter int DEPTH = DefaultDepth
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // item_value[31:0], item_priority[47:32]
   input  wire logic [1:0]  req_tuser,   // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // head_value[31:0], entry_count[36:32],
                                         // is_empty[37], zero[39:38]
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [CountWidth-1:0]   count_ff;
   logic [CountWidth-1:0]   count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [1:0]              rsp_status_ff;
   logic [1:0]              rsp_status_in;
   logic [ValueWidth-1:0]   rsp_head_ff;
   logic [ValueWidth-1:0]   rsp_head_in;
   logic [4:0]              rsp_count_ff;
   logic [4:0]              rsp_count_in;
   logic                    rsp_empty_ff;
   logic                    rsp_empty_in;

   logic                    accept;
   logic [1:0]              action;
   entry_type               new_entry;
   logic                    full;
   logic                    empty_now;
   logic                    is_read;
   ctl_type                 ctl;
   logic [CountWidth+4:0]   count_ext;

   entry_type               cell_q [DEPTH];
   logic                    keep   [DEPTH];

   assign req_tready      = !rsp_valid_ff || rsp_tready;
   assign accept          = req_tvalid && req_tready;
   assign action          = req_tuser;
   assign new_entry.value = req_tdata[31:0];
   assign new_entry.prio  = req_tdata[47:32];

   assign full      = (count_ff == CountWidth'(DEPTH));
   assign empty_now = (count_ff == '0);
   assign is_read   = (action == ActDequeue) || (action == ActPeek);
   assign ctl.enq   = accept && (action == ActEnqueue) && !full;
   assign ctl.deq   = accept && (action == ActDequeue) && !empty_now;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;
      logic      prev_keep;
      logic      occupied;

      assign occupied = (CountWidth'(i) < count_ff);

      if (i == 0) begin : g_head
         assign prev_entry = new_entry;
         assign prev_keep  = 1'b1;
      end else begin : g_body
         assign prev_entry = cell_q[i-1];
         assign prev_keep  = keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_entry = cell_q[i];
      end else begin : g_inner
         assign next_entry = cell_q[i+1];
      end

      mpq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occupied),
         .new_entry  (new_entry),
         .prev_entry (prev_entry),
         .prev_keep  (prev_keep),
         .next_entry (next_entry),
         .entry      (cell_q[i]),
         .keep       (keep[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.enq) begin
         count_in = count_ff + CountWidth'(1);
      end else if (ctl.deq) begin
         count_in = count_ff - CountWidth'(1);
      end

      rsp_status_in = StatusOk;
      rsp_head_in   = '0;
      if ((action == ActEnqueue) && full) begin
         rsp_status_in = StatusOverflow;
      end else if (is_read && empty_now) begin
         rsp_status_in = StatusUnderflow;
      end else if (is_read) begin
         rsp_head_in = cell_q[0].value;
      end

      count_ext    = {5'd0, count_in};
      rsp_count_in = count_ext[4:0];
      rsp_empty_in = (count_in == '0);

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_head_ff   <= rsp_head_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_empty_ff, rsp_count_ff, rsp_head_ff};

endmodule

`default_nettype wire

FILE: hdl/mpq_chk.sv
// Port checker for the sorted priority queue core, bound to the top level.
// Depends on mpq_pkg and max_priority_queue_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "max_priority_queue_core_assert.svh"

module mpq_chk
   import mpq_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   `MPQ_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")
   `MPQ_ASSERT(a_req_to_rsp, req_tvalid && req_tready |=> rsp_tvalid, "accepted item gave no result")
   `MPQ_ASSERT(a_count_empty, rsp_tvalid && (rsp_tdata[36:32] != 5'd0) |-> !rsp_tdata[37], "empty flag with nonzero count")
   `MPQ_ASSERT(a_underflow, rsp_tvalid && (rsp_tuser == StatusUnderflow) |-> (rsp_tdata[31:0] == 32'd0) && rsp_tdata[37], "underflow result not empty or head not zero")
   `MPQ_ASSERT(a_overflow, rsp_tvalid && (rsp_tuser == StatusOverflow) |-> (rsp_tdata[31:0] == 32'd0) && !rsp_tdata[37], "overflow result empty or head not zero")

endmodule

bind max_priority_queue_core mpq_chk u_mpq_chk (.*);

`default_nettype wire

FILE: dv/max_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for max_priority_queue_core: sorted enqueue, dequeue, peek,
// overflow and underflow, checked item by item against an in-bench queue prediction.
// Depends on mpq_pkg and the max_priority_queue_core RTL.

import mpq_pkg::*;

localparam logic [1:0] ActNone = 2'd3;

typedef struct packed {
   logic [1:0]  status;
   logic [31:0] head_value;
   logic [4:0]  entry_count;
   logic        is_empty;
} pq_result_type;

class sorted_queue_scoreboard;
   logic signed [ValueWidth-1:0] slot_value[DefaultDepth];
   logic signed [PrioWidth-1:0]  slot_prio[DefaultDepth];
   int unsigned                  held;
   pq_result_type                pending_results[$];
   int unsigned                  mismatches;
   int unsigned                  requests;
   int unsigned                  checked;
   int unsigned                  overflows;
   int unsigned                  underflows;
   int unsigned                  full_hits;

   function int unsigned pending();
      return pending_results.size();
   endfunction

   function void note_request(logic [1:0] act, logic signed [31:0] val,
                              logic signed [15:0] pri);
      pq_result_type r;
      int unsigned   pos;
      r = '0;
      requests++;
      case (act)
         ActEnqueue: begin
            if (held >= DefaultDepth) begin
               r.status = StatusOverflow;
               overflows++;
            end else begin
               pos = 0;
               while (pos < held && slot_prio[pos] >= pri) pos++;
               for (int i = held; i > pos; i--) begin
                  slot_value[i] = slot_value[i-1];
                  slot_prio[i]  = slot_prio[i-1];
               end
               slot_value[pos] = val;
               slot_prio[pos]  = pri;
               held++;
               if (held == DefaultDepth) full_hits++;
            end
         end
         ActDequeue, ActPeek: begin
            if (held == 0) begin
               r.status = StatusUnderflow;
               underflows++;
            end else begin
               r.head_value = slot_value[0];
               if (act == ActDequeue) begin
                  for (int i = 1; i < held; i++) begin
                     slot_value[i-1] = slot_value[i];
                     slot_prio[i-1]  = slot_prio[i];
                  end
                  held--;
               end
            end
         end
         default: ;
      endcase
      r.entry_count = held[4:0];
      r.is_empty    = (held == 0);
      pending_results.push_back(r);
   endfunction

   function void check_response(logic [1:0] status, logic [39:0] data);
      pq_result_type exp_r;
      if (pending_results.size() == 0) begin
         $error("result with no request outstanding: status %0d data %h", status, data);
         mismatches++;
         return;
      end
      exp_r = pending_results.pop_front();
      checked++;
      if (status !== exp_r.status) begin
         $error("status: expected %0d, got %0d", exp_r.status, status);
         mismatches++;
      end
      if (data[31:0] !== exp_r.head_value) begin
         $error("head_value: expected %h, got %h", exp_r.head_value, data[31:0]);
         mismatches++;
      end
      if (data[36:32] !== exp_r.entry_count) begin
         $error("entry_count: expected %0d, got %0d", exp_r.entry_count, data[36:32]);
         mismatches++;
      end
      if (data[37] !== exp_r.is_empty) begin
         $error("is_empty: expected %0d, got %0d", exp_r.is_empty, data[37]);
         mismatches++;
      end
   endfunction
endclass

module max_priority_queue_core_tb;

   localparam int WatchdogLimit = 2000;
   localparam int PhaseItems    = 406;
   localparam int LongHold      = 80;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = ActEnqueue;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   sorted_queue_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int long_hold_req  = 0;
   int hold_left      = 0;
   int idle_cycles    = 0;

   max_priority_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
      if (long_hold_req > 0) begin
         hold_left     = long_hold_req;
         long_hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left   = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [1:0] act, input logic [31:0] val,
                            input logic [15:0] pri);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pri, val};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, val, pri);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // mode 0 fills, mode 1 drains, mode 2 balances
   task automatic random_item(input int mode);
      int          r;
      int          enq_pct;
      int          deq_pct;
      logic [1:0]  act;
      logic [15:0] pri;
      r       = $urandom_range(99);
      enq_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 45;
      deq_pct = (mode == 0) ? 12 : (mode == 1) ? 60 : 35;
      if (r < enq_pct)                act = ActEnqueue;
      else if (r < enq_pct + deq_pct) act = ActDequeue;
      else if (r < 97)                act = ActPeek;
      else                            act = ActNone;
      if ($urandom_range(1)) pri = 16'($signed($urandom_range(6)) - 3);
      else                   pri = 16'($urandom);
      send_item(act, $urandom, pri);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // underflow and unused action on an empty queue
      send_item(ActDequeue, 32'h1234_5678, 16'h0001);
      send_item(ActPeek,    32'hFFFF_FFFF, 16'hFFFF);
      send_item(ActNone,    32'h0000_0000, 16'h0000);
      // field extremes and equal priorities
      send_item(ActEnqueue, 32'h8000_0000, 16'h8000);
      send_item(ActEnqueue, 32'h7FFF_FFFF, 16'h7FFF);
      send_item(ActEnqueue, 32'h0000_0000, 16'h0000);
      send_item(ActEnqueue, 32'hFFFF_FFFF, 16'h0000);
      send_item(ActEnqueue, 32'h5555_AAAA, 16'hFFFF);
      send_item(ActEnqueue, 32'hAAAA_5555, 16'h0001);
      send_item(ActPeek,    32'h0,         16'h0);
      for (int i = 0; i < 10; i++) send_item(ActEnqueue, 32'h100 + i, 16'd5);
      // full: overflow and no-op
      send_item(ActEnqueue, 32'hDEAD_BEEF, 16'h7FFF);
      send_item(ActEnqueue, 32'hCAFE_F00D, 16'h8000);
      send_item(ActNone,    32'h0,         16'h0);
      send_item(ActDequeue, 32'h0,         16'h0);
      send_item(ActPeek,    32'h0,         16'h0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 62 : 27) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 62 : 27) : 0;
         if (phase == 0) long_hold_req = LongHold;
         for (int n = 0; n < PhaseItems; n++) random_item((n / 24) % 3);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      $display("Run covered %0d requests and %0d checked results across four idling phases.",
               sb.requests, sb.checked);
      $display("Overflows %0d, underflows %0d, queue filled %0d times.",
               sb.overflows, sb.underflows, sb.full_hits);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
